// ===== hw/rtl/rcs_pkg.sv =====
// rcs_pkg: shared types and constants for the rgb contrast stretch block
// used by rcs_lane, rcs_merge, rgb_contrast_stretch_top and its checker

package rcs_pkg;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned DIV_STEPS  = SAMPLE_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_APPLY   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic measure;
        logic restart;
        logic load;
        logic step;
    } t_lane_ctrl;

endpackage

// ===== hw/rtl/rgb_contrast_stretch_top.sv =====
// rgb_contrast_stretch_top: per-channel min/max contrast stretch of rgb pixels
// depends on rcs_pkg, rcs_lane, rcs_merge
//
// Input channel i_valid/o_ready carries a pixel with a command. A measure
// transfer (command 0) updates each channel's running min/max in the cycle
// it is taken; frame_start restarts min/max from that pixel. Measures are
// taken every cycle while idle with no result waiting, and give no output.
// An apply transfer (command 1) loads the three lanes, which divide
// (x-min)*255 by (max-min) side by side, one quotient bit per cycle, in
// the 8-step divider in each lane. The DONE state then moves the result
// into the output register and raises o_valid; no new pixel is taken
// until the sequencer is back in idle.
// Output channel o_valid/i_ready holds the pixel until it is taken; while
// it waits the input is held off, and a new pixel is taken once the
// pending result is taken in the same cycle or earlier.
// Reset (i_rst_n low, synchronous) empties the output register, returns the
// sequencer to idle and sets every min to 255 and every max to 0, so an
// apply before any measure gives zeros.

module rgb_contrast_stretch_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic                          i_frame_start,
    input  logic [rcs_pkg::SAMPLE_W-1:0]  i_red,
    input  logic [rcs_pkg::SAMPLE_W-1:0]  i_green,
    input  logic [rcs_pkg::SAMPLE_W-1:0]  i_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rcs_pkg::SAMPLE_W-1:0]  o_red_out,
    output logic [rcs_pkg::SAMPLE_W-1:0]  o_green_out,
    output logic [rcs_pkg::SAMPLE_W-1:0]  o_blue_out
);

    rcs_pkg::t_state              r_state;
    rcs_pkg::t_state              n_state;
    logic [rcs_pkg::STEP_W-1:0]   r_cnt;
    logic [rcs_pkg::STEP_W-1:0]   n_cnt;
    rcs_pkg::t_lane_ctrl          ctrl;
    logic                         take;
    logic                         out_load;
    logic                         out_valid;
    logic [rcs_pkg::SAMPLE_W-1:0] red_q;
    logic [rcs_pkg::SAMPLE_W-1:0] green_q;
    logic [rcs_pkg::SAMPLE_W-1:0] blue_q;

    assign o_ready = (r_state == rcs_pkg::ST_IDLE) && (!out_valid || i_ready);
    assign take    = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            rcs_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (take && i_command == rcs_pkg::CMD_APPLY) n_state = rcs_pkg::ST_DIV;
            end
            rcs_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rcs_pkg::STEP_W'(rcs_pkg::DIV_STEPS - 1)) begin
                    n_state = rcs_pkg::ST_DONE;
                end
            end
            rcs_pkg::ST_DONE: begin
                n_state = rcs_pkg::ST_IDLE;
            end
            default: n_state = rcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.measure = 1'b0;
        ctrl.restart = i_frame_start;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            rcs_pkg::ST_IDLE: begin
                ctrl.measure = take && (i_command == rcs_pkg::CMD_MEASURE);
                ctrl.load    = take && (i_command == rcs_pkg::CMD_APPLY);
            end
            rcs_pkg::ST_DIV:  ctrl.step = 1'b1;
            rcs_pkg::ST_DONE: out_load  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcs_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    rcs_lane u_lane_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_sample (i_red),
        .o_result (red_q)
    );

    rcs_lane u_lane_green (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_sample (i_green),
        .o_result (green_q)
    );

    rcs_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_sample (i_blue),
        .o_result (blue_q)
    );

    rcs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (out_load),
        .i_red       (red_q),
        .i_green     (green_q),
        .i_blue      (blue_q),
        .o_valid     (out_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    assign o_valid = out_valid;

endmodule

// ===== hw/rtl/rcs_lane.sv =====
// rcs_lane: one color channel, running min/max and a radix-2 restoring divider
// depends on rcs_pkg

module rcs_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcs_pkg::t_lane_ctrl           i_ctrl,
    input  logic [rcs_pkg::SAMPLE_W-1:0]  i_sample,
    output logic [rcs_pkg::SAMPLE_W-1:0]  o_result
);

    localparam int unsigned W = rcs_pkg::SAMPLE_W;

    logic [W-1:0]   r_min;
    logic [W-1:0]   r_max;
    logic [W-1:0]   r_rng;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_sh;
    logic           r_zero;
    logic           r_full;

    logic [W-1:0]   diff;
    logic [2*W-1:0] num;
    logic [W:0]     trial;
    logic           qbit;

    always_comb begin
        diff  = i_sample - r_min;
        num   = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
        trial = {r_rem, r_sh[W-1]};
        qbit  = trial >= {1'b0, r_rng};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= rcs_pkg::FULL_SCALE;
            r_max <= '0;
        end else if (i_ctrl.measure) begin
            if (i_ctrl.restart) begin
                r_min <= i_sample;
                r_max <= i_sample;
            end else begin
                if (i_sample < r_min) r_min <= i_sample;
                if (i_sample > r_max) r_max <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rng  <= r_max - r_min;
            r_rem  <= num[2*W-1:W];
            r_sh   <= num[W-1:0];
            r_zero <= (r_max <= r_min) || (i_sample <= r_min);
            r_full <= i_sample >= r_max;
        end else if (i_ctrl.step) begin
            if (qbit) begin
                r_rem <= trial[W-1:0] - r_rng;
            end else begin
                r_rem <= trial[W-1:0];
            end
            r_sh <= {r_sh[W-2:0], qbit};
        end
    end

    assign o_result = r_zero ? '0 : (r_full ? rcs_pkg::FULL_SCALE : r_sh);

endmodule

// ===== hw/rtl/rcs_merge.sv =====
// rcs_merge: gathers the three lane results into the output register
// depends on rcs_pkg

module rcs_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [rcs_pkg::SAMPLE_W-1:0]  i_red,
    input  logic [rcs_pkg::SAMPLE_W-1:0]  i_green,
    input  logic [rcs_pkg::SAMPLE_W-1:0]  i_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rcs_pkg::SAMPLE_W-1:0]  o_red_out,
    output logic [rcs_pkg::SAMPLE_W-1:0]  o_green_out,
    output logic [rcs_pkg::SAMPLE_W-1:0]  o_blue_out
);

    logic                         r_valid;
    logic [rcs_pkg::SAMPLE_W-1:0] r_red;
    logic [rcs_pkg::SAMPLE_W-1:0] r_green;
    logic [rcs_pkg::SAMPLE_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    assign o_valid     = r_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule

// ===== hw/rtl/rcs_checker.sv =====
// rcs_checker: port-level assertions for rgb_contrast_stretch_top, with bind
// depends on rcs_pkg and rgb_contrast_stretch_top

module rcs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          i_command,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [rcs_pkg::SAMPLE_W-1:0]  o_red_out,
    input logic [rcs_pkg::SAMPLE_W-1:0]  o_green_out,
    input logic [rcs_pkg::SAMPLE_W-1:0]  o_blue_out
);

    logic apply_xfer;
    logic measure_xfer;

    assign apply_xfer   = i_valid && o_ready && (i_command == rcs_pkg::CMD_APPLY);
    assign measure_xfer = i_valid && o_ready && (i_command == rcs_pkg::CMD_MEASURE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_apply_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_xfer |=> !o_ready && !o_valid)
        else $error("ready or stale output right after apply transfer");

    a_measure_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        measure_xfer && !o_valid |=> !o_valid)
        else $error("measure transfer produced output");

endmodule

bind rgb_contrast_stretch_top rcs_checker u_rcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_command   (i_command),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
